[hw/rtl/btcg_pkg.sv]
`default_nettype none

package btcg_pkg;

  // Field widths
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned CH_W     = 11;
  localparam int unsigned BIN_W    = 12;
  localparam int unsigned GROUP_W  = 11;

  // Sizes
  localparam int unsigned NUM_BINS      = 4096;
  localparam int unsigned NUM_CHANNELS  = 2048;
  localparam int unsigned BINS_PER_ITEM = 2;
  localparam int unsigned CACHE_ROWS    = NUM_BINS / BINS_PER_ITEM;
  localparam int unsigned ROW_W         = $clog2(CACHE_ROWS);
  localparam int unsigned LANE_W        = $clog2(BINS_PER_ITEM);
  localparam int unsigned BIN_WORD_W    = 2 * SAMPLE_W;
  localparam int unsigned ROW_DATA_W    = BINS_PER_ITEM * BIN_WORD_W;

  // Clearing pass covers the deeper of the two memories
  localparam int unsigned CLR_DEPTH = (CACHE_ROWS > NUM_CHANNELS) ? CACHE_ROWS : NUM_CHANNELS;
  localparam int unsigned CLR_W     = $clog2(CLR_DEPTH);

  // Beat modes
  localparam logic MODE_DATA  = 1'b0;
  localparam logic MODE_TABLE = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } clr_state_e;

  typedef struct packed {
    logic             active;
    logic [CLR_W-1:0] addr;
  } clr_t;

endpackage

`default_nettype wire

[hw/rtl/btcg_ram.sv]
`default_nettype none

module btcg_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read returns the old word when the same entry is written in that cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hw/rtl/btcg_clear.sv]
`default_nettype none

module btcg_clear import btcg_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  output clr_t      clr_o
);

  clr_state_e       state_q, state_d;
  logic [CLR_W-1:0] addr_q, addr_d;

  // Sweep every entry once after reset, then stay in run
  always_comb begin
    state_d = state_q;
    addr_d  = addr_q;
    case (state_q)
      ST_CLEAR: begin
        if (addr_q == CLR_W'(CLR_DEPTH - 1)) begin
          state_d = ST_RUN;
          addr_d  = '0;
        end else begin
          addr_d = addr_q + CLR_W'(1);
        end
      end
      ST_RUN: begin
        addr_d = '0;
      end
      default: begin
        state_d = ST_CLEAR;
        addr_d  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      addr_q  <= '0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
    end
  end

  assign clr_o.active = (state_q == ST_CLEAR);
  assign clr_o.addr   = addr_q;

endmodule

`default_nettype wire

[hw/rtl/bin_to_channel_gather_buffer_unit.sv]
`default_nettype none
// A data word reaches the output through the registered table read, then cache read.
// Throughput: one word per cycle unless out_ready_i stalls the pipe, bounded by the
// single write and read port of each memory. A table word produces no output.
// Reset: after rst_ni rises both memories are zeroed, one entry a cycle, over all 2048
// entries; in_ready_o stays low until that sweep ends.
module bin_to_channel_gather_buffer_unit import btcg_pkg::*; (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic                       mode_i,
  input  wire logic        [GROUP_W-1:0]  group_i,
  input  wire logic signed [SAMPLE_W-1:0] bin0_i_i,
  input  wire logic signed [SAMPLE_W-1:0] bin0_q_i,
  input  wire logic signed [SAMPLE_W-1:0] bin1_i_i,
  input  wire logic signed [SAMPLE_W-1:0] bin1_q_i,
  input  wire logic        [CH_W-1:0]     table_index_i,
  input  wire logic        [BIN_W-1:0]    table_bin_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic             [CH_W-1:0]     res_id_o,
  output logic signed      [SAMPLE_W-1:0] res_i_o,
  output logic signed      [SAMPLE_W-1:0] res_q_o
);

  clr_t clr;

  logic adv;
  logic accept;
  logic acc_data;
  logic acc_table;

  logic [CH_W-1:0] ch_q, ch_d;

  // Stage 1: table read returned, cache write pending
  logic                  v1_q;
  logic [CH_W-1:0]       ch1_q;
  logic [ROW_W-1:0]      row1_q;
  logic [ROW_DATA_W-1:0] wrow1_q;

  // Stage 2: cache read returned, output word
  logic              v2_q;
  logic [CH_W-1:0]   ch2_q;
  logic [LANE_W-1:0] lane2_q;

  logic [BIN_W-1:0]      tbl_rdata;
  logic                  tbl_we;
  logic [CH_W-1:0]       tbl_waddr;
  logic [BIN_W-1:0]      tbl_wdata;

  logic [ROW_DATA_W-1:0] cache_rdata;
  logic                  cache_we;
  logic [ROW_W-1:0]      cache_waddr;
  logic [ROW_DATA_W-1:0] cache_wdata;
  logic                  cache_re;

  btcg_clear u_clear (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .clr_o  (clr)
  );

  // Handshake: the pipe moves whenever the output slot is free or being taken
  assign adv        = !v2_q || out_ready_i;
  assign in_ready_o = !clr.active && adv;
  assign accept     = in_valid_i && in_ready_o;
  assign acc_data   = accept && (mode_i == MODE_DATA);
  assign acc_table  = accept && (mode_i == MODE_TABLE);

  // Advance the channel counter on every data word, wrap at the channel count
  always_comb begin
    ch_d = ch_q;
    if (acc_data) begin
      if (ch_q == CH_W'(NUM_CHANNELS - 1)) begin
        ch_d = '0;
      end else begin
        ch_d = ch_q + CH_W'(1);
      end
    end
  end

  // Mapping table: loaded by table words, read at the current channel
  assign tbl_we    = clr.active || acc_table;
  assign tbl_waddr = clr.active ? clr.addr[CH_W-1:0] : table_index_i;
  assign tbl_wdata = clr.active ? '0 : table_bin_i;

  btcg_ram #(
    .WIDTH (BIN_W),
    .DEPTH (NUM_CHANNELS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .re_i    (acc_data),
    .raddr_i (ch_q),
    .rdata_o (tbl_rdata)
  );

  // Bin cache: one row per group; read and write of a word happen in the same
  // cycle, the read returning the previous frame, so the next word sees the new row
  assign cache_re    = adv && v1_q;
  assign cache_we    = clr.active || cache_re;
  assign cache_waddr = clr.active ? clr.addr[ROW_W-1:0] : row1_q;
  assign cache_wdata = clr.active ? '0 : wrow1_q;

  btcg_ram #(
    .WIDTH (ROW_DATA_W),
    .DEPTH (CACHE_ROWS)
  ) u_cache (
    .clk_i   (clk_i),
    .we_i    (cache_we),
    .waddr_i (cache_waddr),
    .wdata_i (cache_wdata),
    .re_i    (cache_re),
    .raddr_i (tbl_rdata[BIN_W-1:LANE_W]),
    .rdata_o (cache_rdata)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q <= '0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      ch_q <= ch_d;
      if (adv) begin
        v1_q <= acc_data;
        v2_q <= v1_q;
      end
    end
  end

  // Payload registers: hold while stalled
  always_ff @(posedge clk_i) begin
    if (acc_data) begin
      ch1_q   <= ch_q;
      row1_q  <= group_i[ROW_W-1:0];
      wrow1_q <= {bin1_q_i, bin1_i_i, bin0_q_i, bin0_i_i};
    end
    if (cache_re) begin
      ch2_q   <= ch1_q;
      lane2_q <= tbl_rdata[LANE_W-1:0];
    end
  end

  // Pick the lane of the mapped bin from the returned row
  assign out_valid_o = v2_q;
  assign res_id_o    = ch2_q;
  assign res_i_o     = cache_rdata[32'(lane2_q) * BIN_WORD_W +: SAMPLE_W];
  assign res_q_o     = cache_rdata[32'(lane2_q) * BIN_WORD_W + SAMPLE_W +: SAMPLE_W];

endmodule

`default_nettype wire
